// File: rtl/cds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_pkg: shared types and constants of the CAN datagram segmenter
// Holds the frame record passed from the front part to the back part, the
// identifier configuration bundle, register indexes and the front phases.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned BODY_BYTES = 7;

  localparam logic [7:0] PROTO_BASE   = 8'h30;
  localparam logic [7:0] FIRST_PART   = 8'h01;
  localparam logic [14:0] HDR_EXTRA   = 15'd3;
  localparam logic [3:0] LEN_FIRST_EMPTY = 4'd7;
  localparam logic [3:0] LEN_FULL     = 4'd8;
  localparam logic [2:0] FILL_FULL    = 3'd7;

  localparam int unsigned CFG_DATA_W  = 19;
  localparam int unsigned CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MESSAGE_ID     = 2'd0,
    CFG_RECEIVER_CLASS = 2'd1,
    CFG_DEST_ADDRESS   = 2'd2,
    CFG_UIP_SUBLEVEL   = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_BODY  = 2'd2
  } phase_e;

  typedef enum logic {
    CMD_HEADER  = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [6:0]  message_id;
    logic [2:0]  receiver_class;
    logic [18:0] dest_address;
  } id_cfg_t;

  typedef struct packed {
    logic [7:0]                  part;
    logic [3:0]                  count;
    logic [BODY_BYTES-1:0][7:0]  data;
    logic                        last;
  } frame_t;

endpackage : cds_pkg
`default_nettype wire

// File: rtl/can_datagram_segmenter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_datagram_segmenter_unit: splits datagrams into extended CAN frames
// Header and payload byte requests come in; 29-bit identifier frames go out.
// ----------------------------------------------------------------------------
// Usage. The input side looks like a queue: a request is taken at a rising
// edge with push high and full low. A header request (cmd_i 0) opens a
// datagram, each payload request (cmd_i 1) adds one byte. Frames leave through
// a second queue interface: while empty is low the oldest frame sits on the
// result ports, and it is taken at an edge with pop high.
// Throughput is one request per cycle while full is low, set by the front
// assembly logic, which handles each byte as it is taken. The edge that
// takes the request that finished a frame writes it into the frame queue;
// a later edge moves it into the output register once that register is
// empty or being popped, and it is then on the result ports.
// When the receiver stalls, the output register holds its frame and the
// frame queue (four entries) fills; full rises only when that queue is
// full, and at most one frame is made per request.
// Reset clears the datagram state, empties both queues and loads the
// configuration registers with their defaults. Configuration writes through
// cfg_we_i are taken at once and should be made while the block is idle.
// ----------------------------------------------------------------------------
module can_datagram_segmenter_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cds_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [cds_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            cmd_i,
  input  wire logic                            repeat_flag_i,
  input  wire logic [7:0]                      purpose_code_i,
  input  wire logic [7:0]                      version_code_i,
  input  wire logic [7:0]                      sub_command_i,
  input  wire logic [14:0]                     payload_length_i,
  input  wire logic [7:0]                      data_byte_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [28:0]                          frame_id_o,
  output logic [3:0]                           frame_length_o,
  output logic [7:0]                           byte0_o,
  output logic [7:0]                           byte1_o,
  output logic [7:0]                           byte2_o,
  output logic [7:0]                           byte3_o,
  output logic [7:0]                           byte4_o,
  output logic [7:0]                           byte5_o,
  output logic [7:0]                           byte6_o,
  output logic [7:0]                           byte7_o,
  output logic                                 last_frame_o
);
  import cds_pkg::*;

  // Configuration registers. The sublevel is sampled by the front when a
  // header arrives; the identifier fields are sampled by the back per frame.
  id_cfg_t    id_cfg_q;
  logic [3:0] sublevel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_cfg_q.message_id     <= 7'd116;
      id_cfg_q.receiver_class <= 3'd1;
      id_cfg_q.dest_address   <= '0;
      sublevel_q              <= 4'd3;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_MESSAGE_ID:     id_cfg_q.message_id     <= cfg_wdata_i[6:0];
        CFG_RECEIVER_CLASS: id_cfg_q.receiver_class <= cfg_wdata_i[2:0];
        CFG_DEST_ADDRESS:   id_cfg_q.dest_address   <= cfg_wdata_i[18:0];
        CFG_UIP_SUBLEVEL:   sublevel_q              <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // The input side is ready whenever the frame queue has room, so a byte can
  // be taken every cycle even while a finished frame waits to be popped.
  logic   accept;
  logic   fq_push, fq_pop, fq_full, fq_empty, out_valid;
  frame_t fq_wdata, fq_rdata, out_frame;

  assign full   = fq_full;
  assign accept = push && !fq_full;

  cds_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .cmd_i            (cmd_i),
    .repeat_flag_i    (repeat_flag_i),
    .purpose_code_i   (purpose_code_i),
    .version_code_i   (version_code_i),
    .sub_command_i    (sub_command_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .uip_sublevel_i   (sublevel_q),
    .frame_push_o     (fq_push),
    .frame_o          (fq_wdata)
  );

  cds_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .wdata_i (fq_wdata),
    .pop_i   (fq_pop),
    .rdata_o (fq_rdata),
    .full_o  (fq_full),
    .empty_o (fq_empty)
  );

  cds_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .id_cfg_i      (id_cfg_q),
    .frame_i       (fq_rdata),
    .frame_avail_i (!fq_empty),
    .frame_take_o  (fq_pop),
    .pop_i         (pop),
    .valid_o       (out_valid),
    .frame_id_o    (frame_id_o),
    .frame_o       (out_frame)
  );

  // Frame record to result ports; byte0 is the part number.
  assign empty          = !out_valid;
  assign frame_length_o = out_frame.count;
  assign byte0_o        = out_frame.part;
  assign byte1_o        = out_frame.data[0];
  assign byte2_o        = out_frame.data[1];
  assign byte3_o        = out_frame.data[2];
  assign byte4_o        = out_frame.data[3];
  assign byte5_o        = out_frame.data[4];
  assign byte6_o        = out_frame.data[5];
  assign byte7_o        = out_frame.data[6];
  assign last_frame_o   = out_frame.last;

`ifndef SYNTHESIS
  // Only the final frame of a datagram may be short.
  a_short_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_frame_o) |-> (frame_length_o == LEN_FULL))
    else $error("non-final frame shorter than eight bytes");

  // Frame length stays within one to eight bytes.
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (frame_length_o != 4'd0 && frame_length_o <= LEN_FULL))
    else $error("frame length out of range");

  // Unused trailing byte must be cleared.
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_length_o != LEN_FULL) |-> (byte7_o == 8'd0))
    else $error("unused frame byte not zero");

  // A frame pushed into a full queue would be lost.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_push |-> (!fq_full || fq_pop))
    else $error("frame queue overflow");
`endif

endmodule : can_datagram_segmenter_unit
`default_nettype wire

// File: rtl/cds_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_front: request intake and frame assembly
// Classifies each accepted request as header or payload byte, tracks the
// datagram phase and fills the frame buffer; a finished frame is pushed on.
// ----------------------------------------------------------------------------
module cds_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic                 cmd_i,
  input  wire logic                 repeat_flag_i,
  input  wire logic [7:0]           purpose_code_i,
  input  wire logic [7:0]           version_code_i,
  input  wire logic [7:0]           sub_command_i,
  input  wire logic [14:0]          payload_length_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic [3:0]           uip_sublevel_i,
  output logic                      frame_push_o,
  output cds_pkg::frame_t           frame_o
);
  import cds_pkg::*;

  phase_e                     phase_q, phase_d;
  logic [7:0]                 part_q, part_d;
  logic [14:0]                remaining_q, remaining_d;
  logic [2:0]                 fill_q, fill_d;
  logic [BODY_BYTES-1:0][7:0] buf_q, buf_d;
  logic [BODY_BYTES-1:0][7:0] work;
  logic [14:0]                total;
  logic [14:0]                rem_dec;
  logic [2:0]                 fill_inc;

  assign total    = payload_length_i + HDR_EXTRA;
  assign rem_dec  = remaining_q - 15'd1;
  assign fill_inc = fill_q + 3'd1;

  always_comb begin
    phase_d      = phase_q;
    part_d       = part_q;
    remaining_d  = remaining_q;
    fill_d       = fill_q;
    buf_d        = buf_q;
    work         = buf_q;
    frame_push_o = 1'b0;
    frame_o.part  = part_q;
    frame_o.count = LEN_FULL;
    frame_o.data  = buf_q;
    frame_o.last  = 1'b0;
    if (accept_i) begin
      if (cmd_i == CMD_HEADER) begin
        work    = '0;
        work[0] = PROTO_BASE | {4'd0, uip_sublevel_i};
        work[1] = total[7:0];
        work[2] = {repeat_flag_i, total[14:8]};
        work[3] = purpose_code_i;
        work[4] = version_code_i;
        work[5] = sub_command_i;
        fill_d      = '0;
        remaining_d = payload_length_i;
        frame_o.part  = FIRST_PART;
        frame_o.count = LEN_FIRST_EMPTY;
        frame_o.data  = work;
        frame_o.last  = 1'b1;
        if (payload_length_i == '0) begin
          // Empty datagram: the header alone makes the only frame.
          frame_push_o = 1'b1;
          part_d       = FIRST_PART + 8'd1;
          buf_d        = '0;
          phase_d      = PH_IDLE;
        end else begin
          part_d  = FIRST_PART;
          buf_d   = work;
          phase_d = PH_FIRST;
        end
      end else begin
        case (phase_q)
          PH_FIRST: begin
            work[6]       = data_byte_i;
            frame_push_o  = 1'b1;
            frame_o.count = LEN_FULL;
            frame_o.data  = work;
            frame_o.last  = (rem_dec == '0);
            part_d        = part_q + 8'd1;
            remaining_d   = rem_dec;
            buf_d         = '0;
            fill_d        = '0;
            phase_d       = (rem_dec == '0) ? PH_IDLE : PH_BODY;
          end
          PH_BODY: begin
            if (fill_q != FILL_FULL) begin
              work[fill_q] = data_byte_i;
            end
            remaining_d = rem_dec;
            fill_d      = fill_inc;
            buf_d       = work;
            if (rem_dec == '0 || fill_inc == FILL_FULL) begin
              frame_push_o  = 1'b1;
              frame_o.count = {1'b0, fill_inc} + 4'd1;
              frame_o.data  = work;
              frame_o.last  = (rem_dec == '0);
              part_d        = part_q + 8'd1;
              buf_d         = '0;
              fill_d        = '0;
              if (rem_dec == '0) begin
                phase_d = PH_IDLE;
              end
            end
          end
          default: begin
            // Stray payload byte outside a datagram is dropped.
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      part_q      <= FIRST_PART;
      remaining_q <= '0;
      fill_q      <= '0;
      buf_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      part_q      <= part_d;
      remaining_q <= remaining_d;
      fill_q      <= fill_d;
      buf_q       <= buf_d;
    end
  end

endmodule : cds_front
`default_nettype wire

// File: rtl/cds_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_fifo: frame queue between front and back
// A small register queue of finished frame records so that the intake and
// the result side stall independently.
// ----------------------------------------------------------------------------
module cds_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  cds_pkg::frame_t       wdata_i,
  input  wire logic             pop_i,
  output cds_pkg::frame_t       rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import cds_pkg::*;

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(FIFO_DEPTH);

  frame_t          mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule : cds_fifo
`default_nettype wire

// File: rtl/cds_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_back: frame output stage
// Takes frame records from the queue, builds the extended identifier and
// holds the result in an output register until it is popped.
// ----------------------------------------------------------------------------
module cds_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  cds_pkg::id_cfg_t      id_cfg_i,
  input  cds_pkg::frame_t       frame_i,
  input  wire logic             frame_avail_i,
  output logic                  frame_take_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [28:0]           frame_id_o,
  output cds_pkg::frame_t       frame_o
);
  import cds_pkg::*;

  logic        valid_q;
  logic [28:0] id_q;
  frame_t      frame_q;

  assign frame_take_o = frame_avail_i && (!valid_q || pop_i);
  assign valid_o      = valid_q;
  assign frame_id_o   = id_q;
  assign frame_o      = frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (frame_take_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_take_o) begin
      id_q    <= {id_cfg_i.message_id, id_cfg_i.receiver_class, id_cfg_i.dest_address};
      frame_q <= frame_i;
    end
  end

endmodule : cds_back
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for can_datagram_segmenter_unit
// Header and payload byte requests go in through the push/full queue port.
// A behavioral segmenter inside the bench predicts every CAN frame, and each
// frame popped from the block is compared field by field with the oldest
// prediction. Both sides idle at random, and the receiver stalls for a long
// stretch once so that the frame queue fills and full is exercised.
// ----------------------------------------------------------------------------
module tb;
  import cds_pkg::*;

  // The limit is set far above what a correct run needs even with the heaviest
  // idling, so it only catches a hung block.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned MAX_REPORTS  = 50;

  // One request as it is driven onto the input ports.
  typedef struct packed {
    cmd_e        cmd;
    logic        rpt;
    logic [7:0]  purpose;
    logic [7:0]  version;
    logic [7:0]  subcmd;
    logic [14:0] plen;
    logic [7:0]  data;
  } seg_req_t;

  // One CAN frame as it appears on the result ports; bytes[0] is the part
  // number.
  typedef struct packed {
    logic [28:0]     id;
    logic [3:0]      len;
    logic [7:0][7:0] bytes;
    logic            last;
  } can_frame_t;

  logic                   clk_i;
  logic                   rst_ni       = 1'b0;
  logic                   cfg_we_i     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i  = '0;
  logic                   push         = 1'b0;
  logic                   full;
  logic                   cmd_i        = 1'b0;
  logic                   repeat_flag_i = 1'b0;
  logic [7:0]             purpose_code_i = '0;
  logic [7:0]             version_code_i = '0;
  logic [7:0]             sub_command_i  = '0;
  logic [14:0]            payload_length_i = '0;
  logic [7:0]             data_byte_i  = '0;
  logic                   empty;
  logic                   pop          = 1'b0;
  logic [28:0]            frame_id_o;
  logic [3:0]             frame_length_o;
  logic [7:0]             byte0_o, byte1_o, byte2_o, byte3_o;
  logic [7:0]             byte4_o, byte5_o, byte6_o, byte7_o;
  logic                   last_frame_o;

  can_datagram_segmenter_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .push             (push),
    .full             (full),
    .cmd_i            (cmd_i),
    .repeat_flag_i    (repeat_flag_i),
    .purpose_code_i   (purpose_code_i),
    .version_code_i   (version_code_i),
    .sub_command_i    (sub_command_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .empty            (empty),
    .pop              (pop),
    .frame_id_o       (frame_id_o),
    .frame_length_o   (frame_length_o),
    .byte0_o          (byte0_o),
    .byte1_o          (byte1_o),
    .byte2_o          (byte2_o),
    .byte3_o          (byte3_o),
    .byte4_o          (byte4_o),
    .byte5_o          (byte5_o),
    .byte6_o          (byte6_o),
    .byte7_o          (byte7_o),
    .last_frame_o     (last_frame_o)
  );

  // 12 ns clock period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Segmenter prediction: configuration copy, datagram state and the frames
  // that are due from the block, oldest first.
  // --------------------------------------------------------------------------
  logic [6:0]  cfg_msg_id;
  logic [2:0]  cfg_rx_class;
  logic [18:0] cfg_dest;
  logic [3:0]  cfg_sublevel;

  phase_e      seg_phase;
  logic [7:0]  part_no;
  logic [14:0] bytes_left;
  logic [7:0]  hold_bytes [BODY_BYTES];
  logic [2:0]  fill_cnt;

  can_frame_t  frames_due [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Percentages of cycles in which the sender or the receiver idles.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  // Set by a test to start a long receiver hold-off; counted down below.
  int unsigned stall_cycles_left = 0;
  logic        rx_hold = 1'b0;

  task automatic clear_hold();
    for (int i = 0; i < BODY_BYTES; i++) hold_bytes[i] = 8'h00;
  endtask

  task automatic reset_segmenter_model();
    cfg_msg_id   = 7'd116;
    cfg_rx_class = 3'd1;
    cfg_dest     = 19'd0;
    cfg_sublevel = 4'd3;
    seg_phase    = PH_IDLE;
    part_no      = FIRST_PART;
    bytes_left   = '0;
    fill_cnt     = '0;
    clear_hold();
  endtask

  // Queues one predicted frame. Bytes past the frame length stay zero, and
  // the identifier uses the configuration at the time the frame is made.
  task automatic emit_frame(input logic [3:0] count, input logic last);
    can_frame_t f;
    f.id       = {cfg_msg_id, cfg_rx_class, cfg_dest};
    f.len      = count;
    f.bytes[0] = part_no;
    for (int i = 0; i < BODY_BYTES; i++) begin
      f.bytes[i+1] = ((i + 2) <= count) ? hold_bytes[i] : 8'h00;
    end
    f.last = last;
    frames_due.push_back(f);
    part_no = part_no + 8'd1;
  endtask

  // Advances the prediction by one accepted request.
  task automatic segment_request(input seg_req_t r);
    logic [14:0] total;
    if (r.cmd == CMD_HEADER) begin
      // A header always restarts; whatever was buffered is simply dropped.
      total = r.plen + HDR_EXTRA;
      clear_hold();
      hold_bytes[0] = PROTO_BASE | {4'h0, cfg_sublevel};
      hold_bytes[1] = total[7:0];
      hold_bytes[2] = {r.rpt, total[14:8]};
      hold_bytes[3] = r.purpose;
      hold_bytes[4] = r.version;
      hold_bytes[5] = r.subcmd;
      part_no    = FIRST_PART;
      fill_cnt   = '0;
      bytes_left = r.plen;
      if (r.plen == '0) begin
        emit_frame(LEN_FIRST_EMPTY, 1'b1);
        seg_phase = PH_IDLE;
        clear_hold();
      end else begin
        seg_phase = PH_FIRST;
      end
    end else if (seg_phase == PH_FIRST) begin
      hold_bytes[6] = r.data;
      bytes_left    = bytes_left - 15'd1;
      emit_frame(LEN_FULL, bytes_left == '0);
      clear_hold();
      fill_cnt  = '0;
      seg_phase = (bytes_left == '0) ? PH_IDLE : PH_BODY;
    end else if (seg_phase == PH_BODY) begin
      hold_bytes[fill_cnt] = r.data;
      fill_cnt   = fill_cnt + 3'd1;
      bytes_left = bytes_left - 15'd1;
      if (bytes_left == '0 || fill_cnt == FILL_FULL) begin
        emit_frame({1'b0, fill_cnt} + 4'd1, bytes_left == '0);
        clear_hold();
        fill_cnt = '0;
        if (bytes_left == '0) seg_phase = PH_IDLE;
      end
    end
    // Payload bytes while no datagram is open are ignored.
  endtask

  // --------------------------------------------------------------------------
  // Request construction and driving.
  // --------------------------------------------------------------------------
  function automatic seg_req_t header_req(input logic rpt, input logic [7:0] pc,
                                          input logic [7:0] vc, input logic [7:0] sc,
                                          input logic [14:0] len);
    seg_req_t r;
    r.cmd     = CMD_HEADER;
    r.rpt     = rpt;
    r.purpose = pc;
    r.version = vc;
    r.subcmd  = sc;
    r.plen    = len;
    // The data port is unused on a header, so it carries noise.
    r.data    = 8'($urandom_range(255));
    return r;
  endfunction

  function automatic seg_req_t payload_req(input logic [7:0] d);
    seg_req_t r;
    r.cmd     = CMD_PAYLOAD;
    r.rpt     = 1'($urandom_range(1));
    r.purpose = 8'($urandom_range(255));
    r.version = 8'($urandom_range(255));
    r.subcmd  = 8'($urandom_range(255));
    r.plen    = 15'($urandom_range(32767));
    r.data    = d;
    return r;
  endfunction

  // Offers one request after a random gap and returns at the edge that takes
  // it. push is left high so that a following request can go back to back.
  task automatic send_req(input seg_req_t r);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push             <= 1'b1;
    cmd_i            <= r.cmd;
    repeat_flag_i    <= r.rpt;
    purpose_code_i   <= r.purpose;
    version_code_i   <= r.version;
    sub_command_i    <= r.subcmd;
    payload_length_i <= r.plen;
    data_byte_i      <= r.data;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    segment_request(r);
  endtask

  // Sends a header and then n_data random payload bytes.
  task automatic send_datagram(input logic [14:0] len, input int unsigned n_data);
    send_req(header_req(1'($urandom_range(1)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)), len));
    repeat (n_data) send_req(payload_req(8'($urandom_range(255))));
  endtask

  // Stops offering and waits until every predicted frame has come out, plus
  // a further DRAIN_CYCLES wait for anything still in the two-stage output path.
  task automatic drain();
    push <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_MESSAGE_ID:     cfg_msg_id   = value[6:0];
      CFG_RECEIVER_CLASS: cfg_rx_class = value[2:0];
      CFG_DEST_ADDRESS:   cfg_dest     = value[18:0];
      CFG_UIP_SUBLEVEL:   cfg_sublevel = value[3:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all_regs(input logic [6:0] mid, input logic [2:0] rcls,
                                input logic [18:0] dest, input logic [3:0] sub);
    write_reg(CFG_MESSAGE_ID, CFG_DATA_W'(mid));
    write_reg(CFG_RECEIVER_CLASS, CFG_DATA_W'(rcls));
    write_reg(CFG_DEST_ADDRESS, dest);
    write_reg(CFG_UIP_SUBLEVEL, CFG_DATA_W'(sub));
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random pop, the long hold-off, and the frame check.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_cycles_left != 0) begin
      rx_hold           <= 1'b1;
      stall_cycles_left <= stall_cycles_left - 1;
    end else begin
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    pop <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [28:0] got,
                                 input logic [28:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: frame %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  // A frame is taken at an edge with empty low and pop high; both are read
  // here before the edge updates them.
  always @(posedge clk_i) begin
    can_frame_t got;
    can_frame_t want;
    if (rst_ni && !empty && pop) begin
      got.id    = frame_id_o;
      got.len   = frame_length_o;
      got.bytes = {byte7_o, byte6_o, byte5_o, byte4_o, byte3_o, byte2_o, byte1_o, byte0_o};
      got.last  = last_frame_o;
      if (frames_due.size() == 0) begin
        report_mismatch("with none outstanding, id", got.id, '0);
      end else begin
        want = frames_due.pop_front();
        if (got.id !== want.id) report_mismatch("id", got.id, want.id);
        if (got.len !== want.len) begin
          report_mismatch("length", 29'(got.len), 29'(want.len));
        end
        for (int i = 0; i < 8; i++) begin
          if (got.bytes[i] !== want.bytes[i]) begin
            report_mismatch($sformatf("byte%0d", i), 29'(got.bytes[i]),
                            29'(want.bytes[i]));
          end
        end
        if (got.last !== want.last) begin
          report_mismatch("last", 29'(got.last), 29'(want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("can_datagram_segmenter_unit: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Hand-picked requests under the reset configuration: the field extremes
  // and each corner of the datagram handling.
  task automatic test_directed();
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    // An empty payload makes the header produce a seven-byte final frame.
    send_req(header_req(1'b1, 8'hFF, 8'hFF, 8'hFF, 15'd0));
    // A byte with no datagram open is ignored.
    send_req(payload_req(8'hFF));
    // One payload byte gives a single full, final first frame.
    send_req(header_req(1'b0, 8'h00, 8'h00, 8'h00, 15'd1));
    send_req(payload_req(8'hFF));
    // Eight bytes: the first frame plus exactly one full body frame.
    send_req(header_req(1'b1, 8'h41, 8'h42, 8'h43, 15'd8));
    send_req(payload_req(8'h00));
    repeat (7) send_req(payload_req(8'($urandom_range(255))));
    // This datagram is abandoned by the next header while its first frame is still pending.
    send_req(header_req(1'b0, 8'h55, 8'hAA, 8'h5A, 15'd5));
    // The largest length with the repeat flag, abandoned inside the body
    // with some bytes already buffered.
    send_req(header_req(1'b1, 8'h80, 8'h01, 8'h7F, 15'd32764));
    repeat (3) send_req(payload_req(8'($urandom_range(255))));
    // A new two-byte datagram replaces it.
    send_req(header_req(1'b0, 8'h12, 8'h34, 8'h56, 15'd2));
    send_req(payload_req(8'h00));
    send_req(payload_req(8'hFF));
    // A surplus byte after the datagram closed is ignored.
    send_req(payload_req(8'hA5));
    drain();
  endtask

  // Every register at its largest value, then at zero.
  task automatic test_register_extremes();
    tx_idle_pct = 10;
    rx_idle_pct = 20;
    write_all_regs(7'd127, 3'd7, 19'h7FFFF, 4'd15);
    send_datagram(15'd0, 0);
    send_datagram(15'd9, 9);
    drain();
    write_all_regs(7'd0, 3'd0, 19'h00000, 4'd0);
    send_datagram(15'd0, 0);
    send_datagram(15'd9, 9);
    drain();
  endtask

  // A datagram long enough for the part number to wrap from 255 to 0.
  task automatic test_part_wrap();
    tx_idle_pct = 10;
    rx_idle_pct = 76;
    send_datagram(15'd1800, 1800);
    drain();
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the frame queue fills and the block must refuse input until it drains.
  task automatic test_backpressure();
    tx_idle_pct       = 0;
    rx_idle_pct       = 0;
    stall_cycles_left = 300;
    send_datagram(15'd40, 40);
    repeat (12) send_datagram(15'd0, 0);
    drain();
  endtask

  // Mostly complete datagrams of random size and content, mixed with stray
  // bytes, surplus bytes and datagrams cut short by the next header.
  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned n_data;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    write_all_regs(7'($urandom_range(127)), 3'($urandom_range(7)),
                   19'($urandom_range(524287)), 4'($urandom_range(15)));
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) send_req(payload_req(8'($urandom_range(255))));
      end else if (pick < 18) begin
        len    = $urandom_range(32764);
        n_data = $urandom_range((len < 20) ? len : 20);
        send_datagram(15'(len), n_data);
        sent += 1 + n_data;
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) len = $urandom_range(20);
        else if (pick < 95) len = $urandom_range(60);
        else len = $urandom_range(200);
        send_datagram(15'(len), len);
        sent += 1 + len;
        if ($urandom_range(19) == 0) send_req(payload_req(8'($urandom_range(255))));
      end
    end
    // Close any datagram left open so the block is idle for the next writes.
    send_datagram(15'd0, 0);
    drain();
  endtask

  initial begin
    reset_segmenter_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_extremes();
    test_part_wrap();
    test_backpressure();
    test_random_traffic(10, 76, 30);
    test_random_traffic(76, 10, 30);
    test_random_traffic(0, 0, 30);

    if (mismatch_count == 0) begin
      $display("can_datagram_segmenter_unit: match");
    end else begin
      $display("can_datagram_segmenter_unit: mismatch");
    end
    $finish;
  end

endmodule
